>>> rtl/core/ffpa_pkg.sv
// Shared types and constants of the first-fit pool allocator.
`default_nettype none

package ffpa_pkg;

    localparam int REQ_W     = 13;
    localparam int OFF_W     = 12;
    localparam int STS_W     = 2;
    localparam int NEED_W    = 14;
    localparam int HDR_BYTES = 4;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [STS_W-1:0] {
        STS_OK       = 2'd0,
        STS_NOFIT    = 2'd1,
        STS_NOTFOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_RD_POS,
        MEM_RD_NXT,
        MEM_WR_INIT,
        MEM_WR_SPLIT,
        MEM_WR_USED,
        MEM_WR_FREE
    } t_mem_op;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD,
        ST_CHK,
        ST_SPLIT,
        ST_MARK,
        ST_NRD,
        ST_NCHK,
        ST_FWR,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_mem_op mem_op;
        logic    load;
        logic    hit;
        logic    adv;
        logic    merge;
        logic    res_load;
        t_status res_status;
    } t_cmd;

    typedef struct packed {
        logic op_free;
        logic hit;
        logic split;
        logic at_end;
        logic nxt_free;
    } t_sts;

endpackage

`default_nettype wire

>>> rtl/core/ffpa_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module ffpa_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

>>> rtl/core/ffpa_ctrl.sv
// Allocator controller: request sequencing and handshakes.
`default_nettype none

module ffpa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire ffpa_pkg::t_sts i_sts,
    output ffpa_pkg::t_cmd     o_cmd
);

    ffpa_pkg::t_state  r_state, n_state;
    ffpa_pkg::t_status r_status, n_status;
    logic              r_out_valid;
    logic              w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        case (r_state)
            ffpa_pkg::ST_INIT: n_state = ffpa_pkg::ST_IDLE;
            ffpa_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ffpa_pkg::ST_RD;
                end
            end
            ffpa_pkg::ST_RD: n_state = ffpa_pkg::ST_CHK;
            ffpa_pkg::ST_CHK: begin
                if (i_sts.hit) begin
                    n_status = ffpa_pkg::STS_OK;
                    if (i_sts.op_free) begin
                        n_state = i_sts.at_end ? ffpa_pkg::ST_FWR : ffpa_pkg::ST_NRD;
                    end else begin
                        n_state = i_sts.split ? ffpa_pkg::ST_SPLIT : ffpa_pkg::ST_MARK;
                    end
                end else if (i_sts.at_end) begin
                    n_status = i_sts.op_free ? ffpa_pkg::STS_NOTFOUND : ffpa_pkg::STS_NOFIT;
                    n_state  = ffpa_pkg::ST_DONE;
                end else begin
                    n_state = ffpa_pkg::ST_RD;
                end
            end
            ffpa_pkg::ST_SPLIT: n_state = ffpa_pkg::ST_MARK;
            ffpa_pkg::ST_MARK:  n_state = ffpa_pkg::ST_DONE;
            ffpa_pkg::ST_NRD:   n_state = ffpa_pkg::ST_NCHK;
            ffpa_pkg::ST_NCHK:  n_state = ffpa_pkg::ST_FWR;
            ffpa_pkg::ST_FWR:   n_state = ffpa_pkg::ST_DONE;
            ffpa_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = ffpa_pkg::ST_IDLE;
                end
            end
            default: n_state = ffpa_pkg::ST_INIT;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.res_status = r_status;
        o_in_ready       = 1'b0;
        case (r_state)
            ffpa_pkg::ST_INIT: o_cmd.mem_op = ffpa_pkg::MEM_WR_INIT;
            ffpa_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ffpa_pkg::ST_RD: o_cmd.mem_op = ffpa_pkg::MEM_RD_POS;
            ffpa_pkg::ST_CHK: begin
                o_cmd.hit = i_sts.hit;
                o_cmd.adv = !i_sts.hit;
            end
            ffpa_pkg::ST_SPLIT: o_cmd.mem_op = ffpa_pkg::MEM_WR_SPLIT;
            ffpa_pkg::ST_MARK:  o_cmd.mem_op = ffpa_pkg::MEM_WR_USED;
            ffpa_pkg::ST_NRD:   o_cmd.mem_op = ffpa_pkg::MEM_RD_NXT;
            ffpa_pkg::ST_NCHK:  o_cmd.merge  = i_sts.nxt_free;
            ffpa_pkg::ST_FWR:   o_cmd.mem_op = ffpa_pkg::MEM_WR_FREE;
            ffpa_pkg::ST_DONE:  o_cmd.res_load = w_out_free;
            default: o_cmd.mem_op = ffpa_pkg::MEM_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffpa_pkg::ST_INIT;
            r_status    <= ffpa_pkg::STS_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            if (o_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_accept_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ffpa_pkg::ST_RD))
        else $error("accepted word did not start a header walk");

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken word");

    a_split_then_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffpa_pkg::ST_SPLIT) |=> (r_state == ffpa_pkg::ST_MARK))
        else $error("split header not followed by block mark");

endmodule

`default_nettype wire

>>> rtl/core/ffpa_dp.sv
// Allocator datapath: header RAM, walk pointers and split/merge arithmetic.
`default_nettype none

module ffpa_dp #(
    parameter int POOL_BYTES = 4096
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_func,
    input  wire logic [ffpa_pkg::REQ_W-1:0]   i_req_size,
    input  wire logic [ffpa_pkg::OFF_W-1:0]   i_free_offset,
    input  wire ffpa_pkg::t_cmd               i_cmd,
    output ffpa_pkg::t_sts                    o_sts,
    output logic      [ffpa_pkg::STS_W-1:0]   o_status,
    output logic      [ffpa_pkg::OFF_W-1:0]   o_data_offset
);

    localparam int SW    = $clog2(POOL_BYTES);
    localparam int HW    = SW + 1;
    localparam int DEPTH = POOL_BYTES / 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (SW + 1 > ffpa_pkg::NEED_W + 1) ? SW + 1 : ffpa_pkg::NEED_W + 1;
    localparam logic [CW-1:0] HDR_C  = CW'(ffpa_pkg::HDR_BYTES);
    localparam logic [CW-1:0] POOL_C = CW'(POOL_BYTES);
    localparam logic [SW-1:0] INIT_SZ = SW'(POOL_BYTES - ffpa_pkg::HDR_BYTES);

    logic                          r_func;
    logic [ffpa_pkg::NEED_W-1:0]   r_need;
    logic [ffpa_pkg::OFF_W-1:0]    r_target;
    logic [SW-1:0]                 r_pos;
    logic [SW-1:0]                 r_prev_pos;
    logic [SW-1:0]                 r_prev_sz;
    logic                          r_prev_free;
    logic                          r_have_prev;
    logic [SW-1:0]                 r_cur;
    logic [SW-1:0]                 r_cur_sz;
    logic [SW-1:0]                 r_split_pos;
    logic [SW-1:0]                 r_split_sz;
    logic [SW-1:0]                 r_nxt;
    logic [ffpa_pkg::OFF_W-1:0]    r_res_off;

    logic                          ram_we;
    logic [AW-1:0]                 ram_addr;
    logic [HW-1:0]                 ram_wdata;
    logic [HW-1:0]                 ram_rdata;

    logic                          rd_free;
    logic [SW-1:0]                 rd_sz;
    logic [CW-1:0]                 w_pos_c, w_sz_c, w_need_c, w_next_c;
    logic [CW-1:0]                 w_split_pos_c, w_split_sz_c, w_off_c;
    logic [CW-1:0]                 w_prev_merge_c, w_nxt_merge_c;
    logic                          w_fit, w_split, w_match, w_use_prev;
    logic [ffpa_pkg::NEED_W-1:0]   w_need;

    ffpa_ram #(
        .WIDTH (HW),
        .DEPTH (DEPTH)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign rd_free  = ram_rdata[SW];
    assign rd_sz    = ram_rdata[SW-1:0];

    assign w_need   = ({1'b0, i_req_size} + ffpa_pkg::NEED_W'(3))
                      & ~ffpa_pkg::NEED_W'(3);

    assign w_pos_c        = CW'(r_pos);
    assign w_sz_c         = CW'(rd_sz);
    assign w_need_c       = CW'(r_need);
    assign w_next_c       = w_pos_c + HDR_C + w_sz_c;
    assign w_split_pos_c  = w_pos_c + HDR_C + w_need_c;
    assign w_split_sz_c   = w_sz_c - w_need_c - HDR_C;
    assign w_off_c        = w_pos_c + HDR_C;
    assign w_prev_merge_c = w_sz_c + CW'(r_prev_sz) + HDR_C;
    assign w_nxt_merge_c  = CW'(r_cur_sz) + w_sz_c + HDR_C;

    assign w_fit      = rd_free && (w_sz_c >= w_need_c);
    assign w_split    = w_sz_c > (w_need_c + HDR_C);
    assign w_match    = w_off_c == CW'(r_target);
    assign w_use_prev = r_have_prev && r_prev_free;

    always_comb begin
        o_sts.op_free  = r_func == ffpa_pkg::FUNC_FREE;
        o_sts.hit      = (r_func == ffpa_pkg::FUNC_FREE) ? w_match : w_fit;
        o_sts.split    = w_split;
        o_sts.at_end   = w_next_c >= POOL_C;
        o_sts.nxt_free = rd_free;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_pos[AW+1:2];
        ram_wdata = {1'b1, r_cur_sz};
        case (i_cmd.mem_op)
            ffpa_pkg::MEM_RD_POS: ram_addr = r_pos[AW+1:2];
            ffpa_pkg::MEM_RD_NXT: ram_addr = r_nxt[AW+1:2];
            ffpa_pkg::MEM_WR_INIT: begin
                ram_we    = 1'b1;
                ram_addr  = '0;
                ram_wdata = {1'b1, INIT_SZ};
            end
            ffpa_pkg::MEM_WR_SPLIT: begin
                ram_we    = 1'b1;
                ram_addr  = r_split_pos[AW+1:2];
                ram_wdata = {1'b1, r_split_sz};
            end
            ffpa_pkg::MEM_WR_USED: begin
                ram_we    = 1'b1;
                ram_addr  = r_cur[AW+1:2];
                ram_wdata = {1'b0, r_cur_sz};
            end
            ffpa_pkg::MEM_WR_FREE: begin
                ram_we    = 1'b1;
                ram_addr  = r_cur[AW+1:2];
                ram_wdata = {1'b1, r_cur_sz};
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_have_prev <= 1'b0;
        end else if (i_cmd.load) begin
            r_pos       <= '0;
            r_have_prev <= 1'b0;
        end else if (i_cmd.adv) begin
            r_pos       <= w_next_c[SW-1:0];
            r_have_prev <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= i_func;
            r_need    <= w_need;
            r_target  <= i_free_offset;
            r_res_off <= '0;
        end
        if (i_cmd.adv) begin
            r_prev_pos  <= r_pos;
            r_prev_sz   <= rd_sz;
            r_prev_free <= rd_free;
        end
        if (i_cmd.hit) begin
            if (r_func == ffpa_pkg::FUNC_FREE) begin
                r_cur    <= w_use_prev ? r_prev_pos : r_pos;
                r_cur_sz <= w_use_prev ? w_prev_merge_c[SW-1:0] : rd_sz;
                r_nxt    <= w_next_c[SW-1:0];
            end else begin
                r_cur       <= r_pos;
                r_cur_sz    <= w_split ? w_need_c[SW-1:0] : rd_sz;
                r_split_pos <= w_split_pos_c[SW-1:0];
                r_split_sz  <= w_split_sz_c[SW-1:0];
                r_res_off   <= w_off_c[ffpa_pkg::OFF_W-1:0];
            end
        end
        if (i_cmd.merge) begin
            r_cur_sz <= w_nxt_merge_c[SW-1:0];
        end
        if (i_cmd.res_load) begin
            o_status      <= i_cmd.res_status;
            o_data_offset <= r_res_off;
        end
    end

    a_split_after_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mem_op == ffpa_pkg::MEM_WR_SPLIT) |-> (r_split_pos > r_cur))
        else $error("split header not above its block");

    a_merge_on_free_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge |-> (r_func == ffpa_pkg::FUNC_FREE))
        else $error("neighbor merge during allocate");

endmodule

`default_nettype wire

>>> rtl/core/first_fit_pool_allocator.sv
// Top level of the first-fit pool allocator.
// Manages a POOL_BYTES byte pool as a chain of blocks, each led by a one-word
// header (free flag and data size) kept in a single-port RAM of POOL_BYTES/4
// words. An allocate word rounds its size up to a multiple of 4 and takes the
// first free block that fits, splitting off the rest when it leaves room for
// another header and a nonempty data area; a free word finds the block by its
// data offset and merges it with free neighbors on both sides. Requests are
// handled one at a time. Each visited header is read by the RD state (RAM
// address), then the CHK state (registered read data); the result stage
// waits while the previous result is still untaken. After reset, the INIT
// state writes the initial header before the first word is taken. A finished
// result waits in an output register while the next request is accepted.
`default_nettype none

module first_fit_pool_allocator #(
    parameter int POOL_BYTES = 4096
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_func,
    input  wire logic [ffpa_pkg::REQ_W-1:0] i_req_size,
    input  wire logic [ffpa_pkg::OFF_W-1:0] i_free_offset,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic      [ffpa_pkg::STS_W-1:0] o_status,
    output logic      [ffpa_pkg::OFF_W-1:0] o_data_offset
);

    ffpa_pkg::t_cmd cmd;
    ffpa_pkg::t_sts sts;

    ffpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ffpa_dp #(
        .POOL_BYTES (POOL_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_func        (i_func),
        .i_req_size    (i_req_size),
        .i_free_offset (i_free_offset),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_status      (o_status),
        .o_data_offset (o_data_offset)
    );

endmodule

`default_nettype wire
